FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL: clocked on clk, disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold at a clock edge.
`define ASSERT_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`endif

FILE: hw/rtl/ppg_pkg.sv
// Shared types, constants and the sine table of the plasma pixel generator.
package ppg_pkg;

    localparam int COL_COUNT          = 172;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    // pi in Q30
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_X_FAST    = 3'd0,
        CFG_PHASE_Y         = 3'd1,
        CFG_PHASE_X_SLOW    = 3'd2,
        CFG_PHASE_RADIAL    = 3'd3,
        CFG_BASE_HUE        = 3'd4,
        CFG_BRIGHTNESS_GAIN = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] phase_x_fast;
        logic [7:0] phase_y;
        logic [7:0] phase_x_slow;
        logic [7:0] phase_radial;
        logic [7:0] base_hue;
        logic [8:0] brightness_gain;
    } ppg_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Six hue sectors of the HSV wheel
    typedef enum logic [2:0] {
        HUE_R_TO_Y = 3'd0,
        HUE_Y_TO_G = 3'd1,
        HUE_G_TO_C = 3'd2,
        HUE_C_TO_B = 3'd3,
        HUE_B_TO_M = 3'd4,
        HUE_M_TO_R = 3'd5
    } hue_sector_t;

    typedef logic [7:0] sine_table_t [256];

    // floor(127*sin(k*pi/128)) for k in 0..64, Q30 Taylor series
    function automatic logic [7:0] quarter_sine(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned scaled;
        if (k == 0) begin
            return 8'd0;
        end
        if (k >= 64) begin
            return 8'd127;
        end
        x    = (PI_Q30 * 64'(k)) >> 7;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        scaled = (64'd127 * sum) >> 30;
        return scaled[7:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t tbl;
        int unsigned k;
        logic [7:0]  f;
        for (int i = 0; i < 256; i++) begin
            k = 32'(i) & 32'd127;
            if (k > 64) begin
                k = 128 - k;
            end
            f = quarter_sine(k);
            if (i < 128) begin
                tbl[i] = 8'd128 + f;
            end else if (k == 0) begin
                tbl[i] = 8'd128;
            end else if (k == 64) begin
                tbl[i] = 8'd1;
            end else begin
                tbl[i] = 8'd127 - f;
            end
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

FILE: hw/rtl/ppg_front.sv
// Front end: accepts pixel requests, looks up the four plasma sines, pushes the plasma value.
module ppg_front
    import ppg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ppg_cfg_t      cfg,
    input  logic          pixel_valid,
    output logic          pixel_stall,
    input  logic [9:0]    pixel_row,
    input  logic [7:0]    pixel_col,
    input  logic [7:0]    radial_distance,
    input  queue_status_t q_status,
    output logic          push,
    output logic [7:0]    push_data
);

    localparam logic [15:0] COL_LAST = 16'(COL_COUNT - 1);

    logic        held_reg;
    logic        held_next;
    logic [7:0]  sample_reg [4];
    logic [7:0]  sample_next [4];

    logic        accept;
    logic [8:0]  half_row;
    logic [15:0] col_diff;
    logic [7:0]  half_col;
    logic [7:0]  idx_fast;
    logic [7:0]  idx_slow;
    logic [7:0]  idx_col;
    logic [7:0]  idx_rad;
    logic [9:0]  sum;

    assign pixel_stall = held_reg && q_status.full;
    assign accept      = pixel_valid && !pixel_stall;
    assign push        = held_reg && !q_status.full;

    always_comb
    begin
        half_row = pixel_row[9:1];
        col_diff = COL_LAST - {8'd0, pixel_col};
        half_col = col_diff[8:1];
        idx_fast = {half_row[6:0], 1'b0} + cfg.phase_x_fast;
        idx_slow = half_row[7:0] + cfg.phase_x_slow;
        idx_col  = half_col + {half_col[6:0], 1'b0} + cfg.phase_y;
        idx_rad  = radial_distance + cfg.phase_radial;
        sample_next[0] = SINE_TABLE[idx_fast];
        sample_next[1] = SINE_TABLE[idx_slow];
        sample_next[2] = SINE_TABLE[idx_col];
        sample_next[3] = SINE_TABLE[idx_rad];
    end

    always_comb
    begin
        held_next = held_reg;
        if (accept) begin
            held_next = 1'b1;
        end else if (push) begin
            held_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg <= 1'b0;
        end else begin
            held_reg <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int i = 0; i < 4; i++) begin
                sample_reg[i] <= sample_next[i];
            end
        end
    end

    // Sum of four bytes, divided by four
    assign sum = {2'b00, sample_reg[0]} + {2'b00, sample_reg[1]}
               + {2'b00, sample_reg[2]} + {2'b00, sample_reg[3]};
    assign push_data = sum[9:2];

endmodule

FILE: hw/rtl/ppg_queue.sv
// Short FIFO of plasma values between the front end and the colour pipeline.
module ppg_queue
    import ppg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [7:0]    push_data,
    input  logic          pop,
    output logic [7:0]    pop_data,
    output queue_status_t q_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [7:0]       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/ppg_back.sv
// Colour pipeline: plasma value to hue and brightness, HSV to RGB565, output register.
module ppg_back
    import ppg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  ppg_cfg_t      cfg,
    input  queue_status_t q_status,
    input  logic [7:0]    pop_data,
    output logic          pop,
    output logic          result_valid,
    input  logic          result_stall,
    output logic [15:0]   pixel_rgb565
);

    localparam logic [15:0] VAL_FLOOR   = 16'(40 * 255);
    localparam logic [15:0] VAL_SPAN    = 16'd215;
    localparam logic [16:0] SAT_LIMIT   = 17'(255 * 256);
    localparam logic [15:0] SATURATION  = 16'd235;
    localparam logic [15:0] P_FACTOR    = 16'(255 - 235);

    // stage valids; stage 5 is the output register
    logic [5:1] vld_reg;
    logic [5:1] vld_next;
    logic [5:1] adv;

    logic [7:0]  hue1_reg;
    logic [15:0] term1_reg;
    logic [7:0]  hue2_reg;
    logic [24:0] prod2_reg;
    logic [7:0]  hue3_reg;
    logic [7:0]  val3_reg;
    hue_sector_t sector4_reg;
    logic [7:0]  val4_reg;
    logic [7:0]  p4_reg;
    logic [7:0]  srem4_reg;
    logic [7:0]  sinv4_reg;
    logic [15:0] rgb5_reg;

    logic [7:0]  sv;
    logic [15:0] term1_next;
    logic [16:0] scaled;
    logic [24:0] recip_prod;
    logic [7:0]  q_est;
    logic [16:0] q_back;
    logic [16:0] q_rem;
    logic [7:0]  val3_next;
    hue_sector_t sector;
    logic [7:0]  sector_base;
    logic [7:0]  rem;
    logic [15:0] p_prod;
    logic [15:0] srem_prod;
    logic [15:0] sinv_prod;
    logic [15:0] q_prod;
    logic [15:0] t_prod;
    logic [7:0]  ch_q;
    logic [7:0]  ch_t;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    // handshake: a stage moves when the next one is empty or moving
    always_comb
    begin
        adv[5] = !vld_reg[5] || !result_stall;
        for (int s = 4; s >= 1; s--) begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign pop = adv[1] && !q_status.empty;

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[1]) begin
            vld_next[1] = pop;
        end
        for (int s = 2; s <= 5; s++) begin
            if (adv[s]) begin
                vld_next[s] = vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: hue and unscaled brightness
    always_comb
    begin
        sv         = SINE_TABLE[{pop_data[6:0], 1'b0}];
        term1_next = VAL_FLOOR + VAL_SPAN * {8'd0, sv};
    end

    // stage 3: divide by 255*256 with saturation
    always_comb
    begin
        scaled     = prod2_reg[24:8];
        recip_prod = {scaled, 8'd0} + {8'd0, scaled};
        q_est      = recip_prod[23:16];
        q_back     = {1'b0, q_est, 8'd0} - {9'd0, q_est};
        q_rem      = scaled - q_back;
        if (scaled >= SAT_LIMIT) begin
            val3_next = 8'd255;
        end else if (q_rem >= 17'd255) begin
            val3_next = q_est + 8'd1;
        end else begin
            val3_next = q_est;
        end
    end

    // stage 4: sector, offset within sector and saturation terms
    always_comb
    begin
        if (hue3_reg >= 8'd215) begin
            sector = HUE_M_TO_R;  sector_base = 8'd215;
        end else if (hue3_reg >= 8'd172) begin
            sector = HUE_B_TO_M;  sector_base = 8'd172;
        end else if (hue3_reg >= 8'd129) begin
            sector = HUE_C_TO_B;  sector_base = 8'd129;
        end else if (hue3_reg >= 8'd86) begin
            sector = HUE_G_TO_C;  sector_base = 8'd86;
        end else if (hue3_reg >= 8'd43) begin
            sector = HUE_Y_TO_G;  sector_base = 8'd43;
        end else begin
            sector = HUE_R_TO_Y;  sector_base = 8'd0;
        end
        rem       = 8'((hue3_reg - sector_base) * 8'd6);
        p_prod    = {8'd0, val3_reg} * P_FACTOR;
        srem_prod = SATURATION * {8'd0, rem};
        sinv_prod = SATURATION * {8'd0, 8'd255 - rem};
    end

    // stage 5: ramps, channel selection and packing
    always_comb
    begin
        q_prod = {8'd0, val4_reg} * {8'd0, 8'd255 - srem4_reg};
        t_prod = {8'd0, val4_reg} * {8'd0, 8'd255 - sinv4_reg};
        ch_q   = q_prod[15:8];
        ch_t   = t_prod[15:8];
        unique case (sector4_reg)
            HUE_R_TO_Y: begin red = val4_reg; green = ch_t;     blue = p4_reg;   end
            HUE_Y_TO_G: begin red = ch_q;     green = val4_reg; blue = p4_reg;   end
            HUE_G_TO_C: begin red = p4_reg;   green = val4_reg; blue = ch_t;     end
            HUE_C_TO_B: begin red = p4_reg;   green = ch_q;     blue = val4_reg; end
            HUE_B_TO_M: begin red = ch_t;     green = p4_reg;   blue = val4_reg; end
            default:    begin red = val4_reg; green = p4_reg;   blue = ch_q;     end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[1]) begin
            hue1_reg  <= cfg.base_hue + {1'b0, pop_data[7:1]};
            term1_reg <= term1_next;
        end
        if (adv[2]) begin
            hue2_reg  <= hue1_reg;
            prod2_reg <= 25'(term1_reg) * 25'(cfg.brightness_gain);
        end
        if (adv[3]) begin
            hue3_reg <= hue2_reg;
            val3_reg <= val3_next;
        end
        if (adv[4]) begin
            sector4_reg <= sector;
            val4_reg    <= val3_reg;
            p4_reg      <= p_prod[15:8];
            srem4_reg   <= srem_prod[15:8];
            sinv4_reg   <= sinv_prod[15:8];
        end
        if (adv[5]) begin
            rgb5_reg <= {red[7:3], green[7:2], blue[7:3]};
        end
    end

    assign result_valid = vld_reg[5];
    assign pixel_rgb565 = rgb5_reg;

endmodule

FILE: hw/rtl/plasma_pixel_generator.sv
// Top level of the plasma pixel generator: configuration registers, front end, queue, back end.
//
// One pixel request word (row, column, radial distance byte) goes in and one RGB565 word
// comes out, in order. The block takes a new request every clock while pixel_stall is low:
// sustained rate is one pixel per cycle, set by the fully pipelined colour path, where no
// stage chains more than two multiplies. From acceptance a word passes the sine lookup
// register and the queue, then climbs the five colour registers, the last of which is the
// output register. When the result side stalls, the colour pipeline fills first and then
// the queue of QUEUE_DEPTH words; pixel_stall rises only once the queue is full and the
// front stage holds a word. The sine table is a constant and needs no fill after reset.
// Configuration is taken on any cycle with cfg_write_en high; write it only while the
// block is idle. Rows are not checked against the frame height: their sine indices
// simply wrap.
`include "assert_macros.svh"

module plasma_pixel_generator
    import ppg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                   pixel_valid,
    output logic                   pixel_stall,
    input  logic [9:0]             pixel_row,
    input  logic [7:0]             pixel_col,
    input  logic [7:0]             radial_distance,
    // result channel
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [15:0]            pixel_rgb565
);

    ppg_cfg_t      cfg_reg;
    ppg_cfg_t      cfg_next;
    queue_status_t q_status;
    logic          push;
    logic [7:0]    push_data;
    logic          pop;
    logic [7:0]    pop_data;

    // Decode the register index; drop writes to unknown indices
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PHASE_X_FAST:    cfg_next.phase_x_fast    = cfg_data[7:0];
                CFG_PHASE_Y:         cfg_next.phase_y         = cfg_data[7:0];
                CFG_PHASE_X_SLOW:    cfg_next.phase_x_slow    = cfg_data[7:0];
                CFG_PHASE_RADIAL:    cfg_next.phase_radial    = cfg_data[7:0];
                CFG_BASE_HUE:        cfg_next.base_hue        = cfg_data[7:0];
                CFG_BRIGHTNESS_GAIN: cfg_next.brightness_gain = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the frame settings; gain resets to 115/256
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.phase_x_fast    <= 8'd0;
            cfg_reg.phase_y         <= 8'd0;
            cfg_reg.phase_x_slow    <= 8'd0;
            cfg_reg.phase_radial    <= 8'd0;
            cfg_reg.base_hue        <= 8'd0;
            cfg_reg.brightness_gain <= 9'd115;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Accept requests and turn them into plasma values
    ppg_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .pixel_valid     (pixel_valid),
        .pixel_stall     (pixel_stall),
        .pixel_row       (pixel_row),
        .pixel_col       (pixel_col),
        .radial_distance (radial_distance),
        .q_status        (q_status),
        .push            (push),
        .push_data       (push_data)
    );

    // Decouple the two halves so each can stall on its own
    ppg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    // Colour the plasma values and present result words
    ppg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_status     (q_status),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_rgb565 (pixel_rgb565)
    );

    `ASSERT_NEVER(a_no_push_when_full, push && q_status.full)
    `ASSERT_NEVER(a_no_pop_when_empty, pop && q_status.empty)
    `ASSERT_IMPLIES(a_stall_only_on_full_queue, pixel_stall, q_status.full)

endmodule
